[rtl/double_ended_queue_assert.svh]
// assertion macros for the double-ended queue checker
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// checked only outside reset
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/deq_pkg.sv]
// package with types, codes and helpers of the double-ended queue
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [2:0] F_PUSH_FRONT = 3'd0;
    localparam logic [2:0] F_POP_FRONT  = 3'd1;
    localparam logic [2:0] F_PUSH_BACK  = 3'd2;
    localparam logic [2:0] F_POP_BACK   = 3'd3;
    localparam logic [2:0] F_DUMP       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
        logic                     last;
    } t_out_item;

    // ring address: ptr + off modulo DEPTH, off at most DEPTH
    function automatic logic [PTR_W-1:0] deq_wrap(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - PTR_W){1'b0}}, ptr} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/deq_ram.sv]
// simple dual-port ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/double_ended_queue.sv]
// Bounded double-ended queue of signed 32-bit values held in a ring ram
// addressed by a front pointer and an occupancy count. Push front/back
// and any refused or empty operation load their one result beat into the
// output register at the accepting edge, and such items can be taken
// every cycle while the output side keeps up. A pop reads the ram at
// the accepting edge and loads the read data from state S_RD; a dump
// reads the ram once per entry, with o_in_stall high after the
// accepting cycle until the final beat is loaded. Output stalls
// lengthen both. A stalled output holds the current
// result beat in the output register; one further immediate result is
// parked until the register frees. Unused func codes are taken and
// dropped with no result. Ram contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue import deq_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire logic      i_out_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [PTR_W-1:0] r_fp, n_fp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PTR_W-1:0] r_idx, n_idx;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic             r_dump, n_dump;
    t_out_item        r_pend, n_pend;
    logic             r_out_valid;
    t_out_item        r_out;

    logic              wr_en, rd_en;
    logic [PTR_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              out_free, out_load;
    t_out_item         out_next, imm;
    logic              have_imm, is_full, is_empty, rd_last;
    logic [PTR_W-1:0]  fp_dec, fp_inc;
    logic [CNT_W-1:0]  cnt_dec;

    deq_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_full    = (r_cnt == CNT_W'(DEPTH));
    assign is_empty   = (r_cnt == '0);
    assign cnt_dec    = r_cnt - 1'b1;
    assign fp_dec     = (r_fp == '0) ? PTR_W'(DEPTH - 1) : r_fp - 1'b1;
    assign fp_inc     = deq_wrap(r_fp, CNT_W'(1));
    assign rd_last    = !r_dump || (r_idx == cnt_dec[PTR_W-1:0]);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_fp     = r_fp;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_rd_ptr = r_rd_ptr;
        n_dump   = r_dump;
        n_pend   = r_pend;
        wr_en    = 1'b0;
        wr_addr  = fp_dec;
        rd_en    = 1'b0;
        rd_addr  = r_fp;
        out_load = 1'b0;
        out_next = r_pend;
        have_imm = 1'b0;
        imm      = '{result_value: '0, status: ST_OK, last: 1'b1};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.func)
                        F_PUSH_FRONT, F_PUSH_BACK: begin
                            have_imm = 1'b1;
                            if (is_full) begin
                                imm.status = ST_FULL;
                            end else begin
                                wr_en = 1'b1;
                                n_cnt = r_cnt + 1'b1;
                                if (i_in_data.func == F_PUSH_FRONT) begin
                                    wr_addr = fp_dec;
                                    n_fp    = fp_dec;
                                end else begin
                                    wr_addr = deq_wrap(r_fp, r_cnt);
                                end
                            end
                        end
                        F_POP_FRONT, F_POP_BACK: begin
                            if (is_empty) begin
                                have_imm   = 1'b1;
                                imm.status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_cnt   = cnt_dec;
                                n_dump  = 1'b0;
                                n_state = S_RD;
                                if (i_in_data.func == F_POP_FRONT) begin
                                    rd_addr = r_fp;
                                    n_fp    = fp_inc;
                                end else begin
                                    rd_addr = deq_wrap(r_fp, cnt_dec);
                                end
                            end
                        end
                        F_DUMP: begin
                            if (is_empty) begin
                                have_imm   = 1'b1;
                                imm.status = ST_EMPTY;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = r_fp;
                                n_rd_ptr = r_fp;
                                n_idx    = '0;
                                n_dump   = 1'b1;
                                n_state  = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (have_imm) begin
                        if (out_free) begin
                            out_load = 1'b1;
                            out_next = imm;
                        end else begin
                            n_pend  = imm;
                            n_state = S_OUT;
                        end
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_next = r_pend;
                    n_state  = S_IDLE;
                end
            end
            S_RD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_next = '{result_value: rd_data, status: ST_OK, last: rd_last};
                    if (rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = deq_wrap(r_rd_ptr, CNT_W'(1));
                        n_rd_ptr = rd_addr;
                        n_idx    = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fp        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fp    <= n_fp;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_rd_ptr <= n_rd_ptr;
        r_dump   <= n_dump;
        r_pend   <= n_pend;
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[rtl/deq_checker.sv]
// port-level checker for the double-ended queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_assert.svh"

module deq_checker import deq_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire t_in_item  i_in_data,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_item o_out_data,
    input wire logic      i_out_stall
);

    `DEQ_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "beat valid after reset")
    `DEQ_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled beat changed")
    `DEQ_ASSERT(a_status_code, o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.status == ST_EMPTY || o_out_data.status == ST_FULL), "bad status")
    `DEQ_ASSERT(a_error_beat, o_out_valid && o_out_data.status != ST_OK |-> o_out_data.last && o_out_data.result_value == 0, "error beat not final or nonzero")

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire
